/* rtl/tcp_stream_reassembler_assert.svh */
// ---------------------------------------------------------------------------
// tcp_stream_reassembler_assert.svh
// Assertion macros used by the reassembler back end (trs_back).
// ---------------------------------------------------------------------------
`ifndef TCP_STREAM_REASSEMBLER_ASSERT_SVH
`define TCP_STREAM_REASSEMBLER_ASSERT_SVH

// cond must never hold while out of reset
`define TRS_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("reassembler: forbidden condition");

// a at one edge forces b at the next
`define TRS_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("reassembler: sequence violated");

`endif

/* rtl/trs_pkg.sv */
// ---------------------------------------------------------------------------
// trs_pkg
// Types and constants of the stream reassembler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trs_pkg;

	// ring size; slot = index mod CAPACITY, taken as the low index bits
	localparam int CAPACITY = 4096;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int IDX_W    = 32;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 13;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_EOF  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_EOF,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   index;
		logic [BYTE_W-1:0]  value;
		logic               eof;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} bk_status_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_PUSH,
		B_WALK_RD,
		B_WALK_CK,
		B_READ,
		B_RESULT
	} bk_state_t;

endpackage

/* rtl/trs_front.sv */
// ---------------------------------------------------------------------------
// trs_front
// Takes words on the start/busy port, decodes the op and hands the command on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic [trs_pkg::IDX_W-1:0] index,
	input  logic [trs_pkg::BYTE_W-1:0] value,
	input  logic                      eof,
	input  trs_pkg::bk_status_t       status,
	input  logic                      q_full,
	output logic                      q_push,
	output trs_pkg::cmd_t             q_cmd
);
	import trs_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;
	logic      take;

	always_comb begin
		unique case (op)
			OP_PUSH: kind = CMD_PUSH;
			OP_EOF:  kind = CMD_EOF;
			OP_READ: kind = CMD_READ;
			default: kind = CMD_NOP;
		endcase
	end

	assign busy   = status.clearing || (valid_s1 && q_full);
	assign take   = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= '{kind: kind, index: index, value: value, eof: eof};
		end
	end

endmodule

/* rtl/trs_queue.sv */
// ---------------------------------------------------------------------------
// trs_queue
// Short command queue between the front end and the execution back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  trs_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output trs_pkg::cmd_t head,
	output logic          empty
);
	import trs_pkg::*;

	cmd_t                entries [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

/* rtl/trs_back.sv */
// ---------------------------------------------------------------------------
// trs_back
// Executes commands: window test, ring store, assembly walk, reads, results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  trs_pkg::cmd_t               q_head,
	output logic                        q_pop,
	output trs_pkg::bk_status_t         status,
	output logic                        done,
	output logic [trs_pkg::BYTE_W-1:0]  read_value,
	output logic                        read_valid,
	output logic                        accepted,
	output logic [trs_pkg::IDX_W-1:0]   assembly_point,
	output logic [trs_pkg::CNT_W-1:0]   unassembled_count,
	output logic [trs_pkg::IDX_W-1:0]   window_end,
	output logic                        stream_ended
);
	import trs_pkg::*;
	`include "tcp_stream_reassembler_assert.svh"

	logic              valid_mem [CAPACITY];
	logic [BYTE_W-1:0] ring_mem  [CAPACITY];

	bk_state_t         state_q, state_d;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  rp_q, ap_q;
	logic [CNT_W-1:0]  pending_q;
	logic              eof_q;
	logic [SLOT_W-1:0] clr_q;
	logic              done_q;
	logic              acc_q, rok_q;
	logic [BYTE_W-1:0] rval_q;
	logic              vrd_q;
	logic [BYTE_W-1:0] rrd_q;

	logic              v_we, v_wd, v_re;
	logic [SLOT_W-1:0] v_wa, v_ra;
	logic              r_we, r_re;
	logic [SLOT_W-1:0] r_wa, r_ra;
	logic [IDX_W-1:0]  offset, room, wend;
	logic              push_ok;

	assign wend    = rp_q + IDX_W'(CAPACITY);
	assign offset  = cmd_q.index - ap_q;
	assign room    = wend - ap_q;
	assign push_ok = (offset < room) && !vrd_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR:   if (clr_q == SLOT_W'(CAPACITY - 1)) state_d = B_IDLE;
			B_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						CMD_PUSH: state_d = B_PUSH;
						CMD_READ: state_d = B_READ;
						default:  state_d = B_RESULT;
					endcase
				end
			end
			B_PUSH:    state_d = push_ok ? B_WALK_RD : B_RESULT;
			B_WALK_RD: state_d = B_WALK_CK;
			B_WALK_CK: state_d = vrd_q ? B_WALK_RD : B_RESULT;
			B_READ:    state_d = B_RESULT;
			B_RESULT:  state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		v_we  = 1'b0;
		v_wa  = cmd_q.index[SLOT_W-1:0];
		v_wd  = 1'b0;
		v_re  = 1'b0;
		v_ra  = ap_q[SLOT_W-1:0];
		r_we  = 1'b0;
		r_wa  = cmd_q.index[SLOT_W-1:0];
		r_re  = 1'b0;
		r_ra  = rp_q[SLOT_W-1:0];
		unique case (state_q) inside
			B_CLEAR: begin
				v_we = 1'b1;
				v_wa = clr_q;
			end
			B_IDLE: begin
				q_pop = !q_empty;
				v_re  = !q_empty;
				v_ra  = q_head.index[SLOT_W-1:0];
				r_re  = !q_empty;
			end
			B_PUSH: begin
				v_we = push_ok;
				v_wd = 1'b1;
				r_we = push_ok;
			end
			B_WALK_RD: v_re = 1'b1;
			B_WALK_CK: begin
				v_we = vrd_q;
				v_wa = ap_q[SLOT_W-1:0];
			end
			B_READ, B_RESULT: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_we) valid_mem[v_wa] <= v_wd;
		if (v_re) vrd_q <= valid_mem[v_ra];
	end

	always_ff @(posedge clk) begin
		if (r_we) ring_mem[r_wa] <= cmd_q.value;
		if (r_re) rrd_q <= ring_mem[r_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			rp_q      <= '0;
			ap_q      <= '0;
			pending_q <= '0;
			eof_q     <= 1'b0;
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == B_RESULT);
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == B_IDLE && !q_empty && q_head.kind == CMD_EOF) eof_q <= 1'b1;
			if (state_q == B_PUSH && push_ok) begin
				pending_q <= pending_q + 1'b1;
				if (cmd_q.eof) eof_q <= 1'b1;
			end
			if (state_q == B_WALK_CK && vrd_q) begin
				ap_q      <= ap_q + 1'b1;
				pending_q <= pending_q - 1'b1;
			end
			if (state_q == B_READ && ap_q != rp_q) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !q_empty) begin
			cmd_q  <= q_head;
			acc_q  <= 1'b0;
			rok_q  <= 1'b0;
			rval_q <= '0;
		end
		if (state_q == B_PUSH && push_ok) acc_q <= 1'b1;
		if (state_q == B_READ && ap_q != rp_q) begin
			rok_q  <= 1'b1;
			rval_q <= rrd_q;
		end
	end

	assign status.clearing   = (state_q == B_CLEAR);
	assign done              = done_q;
	assign read_value        = rval_q;
	assign read_valid        = rok_q;
	assign accepted          = acc_q;
	assign assembly_point    = ap_q;
	assign unassembled_count = pending_q;
	assign window_end        = wend;
	assign stream_ended      = eof_q && (pending_q == '0);

	`TRS_ASSERT_NEVER(a_pending_bound, pending_q > CNT_W'(CAPACITY))
	`TRS_ASSERT_NEVER(a_ptr_order, (ap_q - rp_q) > IDX_W'(CAPACITY))
	`TRS_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`TRS_ASSERT_NEVER(a_no_pop_clear, q_pop && (state_q == B_CLEAR))

endmodule

/* rtl/tcp_stream_reassembler.sv */
// Path: a command is registered in the front end, queued, taken by the back end in
// IDLE; eof or unused ops go to RESULT, reads via READ, pushes via PUSH; a stored
// push then walks the valid map (WALK_RD, WALK_CK) for each contiguous byte.
// Throughput: one command at a time in the back end; the two-entry queue absorbs
// arrivals. Reset: pointers, counts and eof clear at once; the valid map is then
// swept one slot a cycle over 4096 slots, busy high. Results cannot be stalled.
// ---------------------------------------------------------------------------
// tcp_stream_reassembler
// Out-of-order byte stream reassembly into one shared ring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_stream_reassembler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  op,
	input  logic [trs_pkg::IDX_W-1:0]   index,
	input  logic [trs_pkg::BYTE_W-1:0]  value,
	input  logic                        eof,
	output logic                        done,
	output logic [trs_pkg::BYTE_W-1:0]  read_value,
	output logic                        read_valid,
	output logic                        accepted,
	output logic [trs_pkg::IDX_W-1:0]   assembly_point,
	output logic [trs_pkg::CNT_W-1:0]   unassembled_count,
	output logic [trs_pkg::IDX_W-1:0]   window_end,
	output logic                        stream_ended
);
	import trs_pkg::*;

	bk_status_t status;
	logic       q_full, q_push, q_empty, q_pop;
	cmd_t       q_cmd, q_head;

	trs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.index  (index),
		.value  (value),
		.eof    (eof),
		.status (status),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	trs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	trs_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.status            (status),
		.done              (done),
		.read_value        (read_value),
		.read_valid        (read_valid),
		.accepted          (accepted),
		.assembly_point    (assembly_point),
		.unassembled_count (unassembled_count),
		.window_end        (window_end),
		.stream_ended      (stream_ended)
	);

endmodule
